// ===== hw/rtl/raycast_column_texture_walker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the raycast column texture walker
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_COLUMN_TEXTURE_WALKER_CORE_DEFINES_SVH
`define RAYCAST_COLUMN_TEXTURE_WALKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RCTW_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while in reset.
`define RCTW_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/rctw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rctw_pkg
// Types, codes and constants shared by the column texture walker modules.
// ----------------------------------------------------------------------------
package rctw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_SCREEN    = 2048;
  localparam int MAX_TEX       = 256;

  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int TEXW_W   = 9;   // tex_width / tex_height
  localparam int SCR_W    = 12;  // screen_width / screen_height
  localparam int ROW_CMP_W = 13; // row compares against heights up to 4095
  localparam int LH_W     = 16;
  localparam int STEP_W   = 32;
  localparam int POS_W    = 40;
  localparam int OFF_W    = 17;
  localparam int PROD_W   = 43;  // 25-bit unsigned-as-signed times 18-bit signed

  localparam logic [7:0] TEX_COL_MASK = 8'(MAX_TEX - 1);

  typedef enum logic [2:0] {
    CFG_TEX_WIDTH     = 3'd0,
    CFG_TEX_HEIGHT    = 3'd1,
    CFG_SCREEN_WIDTH  = 3'd2,
    CFG_SCREEN_HEIGHT = 3'd3,
    CFG_SKY_COLOR     = 3'd4,
    CFG_FLOOR_COLOR   = 3'd5
  } cfg_reg_t;

  localparam logic [1:0] REGION_SKY   = 2'd0;
  localparam logic [1:0] REGION_WALL  = 2'd1;
  localparam logic [1:0] REGION_FLOOR = 2'd2;

  localparam logic [1:0] TEX_NORTH = 2'd0;
  localparam logic [1:0] TEX_SOUTH = 2'd1;
  localparam logic [1:0] TEX_WEST  = 2'd2;
  localparam logic [1:0] TEX_EAST  = 2'd3;

  localparam logic OP_COLUMN = 1'b0;
  localparam logic OP_ROW    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_COL,
    ST_MIRR,
    ST_DIV,
    ST_POS
  } ctrl_state_t;

  typedef struct packed {
    logic        op;
    logic [10:0] column;
    logic [21:0] pos_x;
    logic [21:0] pos_y;
    logic [17:0] ray_dir_x;
    logic [17:0] ray_dir_y;
    logic [23:0] perp_dist;
    logic        hit_side;
    logic [15:0] line_height;
    logic [10:0] draw_start;
    logic [10:0] draw_end;
  } in_item_t;

  typedef struct packed {
    logic        last_row;
    logic [23:0] flat_color;
    logic [15:0] texel_index;
    logic [1:0]  texture_id;
    logic [1:0]  region;
    logic [21:0] pixel_addr;
  } out_item_t;

  typedef struct packed {
    logic col_load;
    logic row_load;
    logic prod_en;
    logic sum_en;
    logic col_en;
    logic mirr_en;
    logic pos_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic queue_full;
    logic div_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rctw_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rctw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rctw_div #(
  parameter int DIVIDEND_W = 25,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  last
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = ~diff[DIVISOR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(DIVIDEND_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign last     = (cnt_r == CNT_W'(1));

endmodule
`default_nettype wire

// ===== hw/rtl/rctw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rctw_ctrl
// Sequencer for column setup; issues row and setup commands to the datapath.
// ----------------------------------------------------------------------------
module rctw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_op,
  output logic                  in_tready,
  input  rctw_pkg::dp_status_t  status,
  output rctw_pkg::ctrl_cmd_t   cmd
);

  rctw_pkg::ctrl_state_t state_r;
  rctw_pkg::ctrl_state_t state_nxt;
  logic                  accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rctw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rctw_pkg::ST_IDLE: begin
        if (accept && (in_op == rctw_pkg::OP_COLUMN)) begin
          state_nxt = rctw_pkg::ST_PROD;
        end
      end
      rctw_pkg::ST_PROD: state_nxt = rctw_pkg::ST_SUM;
      rctw_pkg::ST_SUM:  state_nxt = rctw_pkg::ST_COL;
      rctw_pkg::ST_COL:  state_nxt = rctw_pkg::ST_MIRR;
      rctw_pkg::ST_MIRR: state_nxt = rctw_pkg::ST_DIV;
      rctw_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = rctw_pkg::ST_POS;
        end
      end
      rctw_pkg::ST_POS:  state_nxt = rctw_pkg::ST_IDLE;
      default:           state_nxt = rctw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      rctw_pkg::ST_IDLE: begin
        in_tready    = !status.queue_full;
        cmd.col_load = in_tvalid && !status.queue_full && (in_op == rctw_pkg::OP_COLUMN);
        cmd.row_load = in_tvalid && !status.queue_full && (in_op == rctw_pkg::OP_ROW);
      end
      rctw_pkg::ST_PROD: cmd.prod_en = 1'b1;
      rctw_pkg::ST_SUM:  cmd.sum_en  = 1'b1;
      rctw_pkg::ST_COL:  cmd.col_en  = 1'b1;
      rctw_pkg::ST_MIRR: cmd.mirr_en = 1'b1;
      rctw_pkg::ST_DIV:  cmd         = '0;
      rctw_pkg::ST_POS:  cmd.pos_en  = 1'b1;
      default:           cmd         = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rctw_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rctw_datapath
// Configuration registers, column setup arithmetic, per-row pixel
// generation and a two-entry result queue.
// ----------------------------------------------------------------------------
module rctw_datapath #(
  parameter int FRAC_BITS = rctw_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rctw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rctw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  rctw_pkg::in_item_t              in_item,
  input  rctw_pkg::ctrl_cmd_t             cmd,
  output rctw_pkg::dp_status_t            status,
  output rctw_pkg::out_item_t             out_item,
  output logic                            out_valid,
  input  logic                            out_ready
);

  localparam int HW    = 2 * FRAC_BITS;
  localparam int DW    = rctw_pkg::TEXW_W + FRAC_BITS;
  localparam int QX    = (DW > rctw_pkg::STEP_W) ? DW : rctw_pkg::STEP_W + 1;
  localparam int CPW   = FRAC_BITS + rctw_pkg::TEXW_W;

  // configuration
  logic [8:0]  tex_width_r;
  logic [8:0]  tex_height_r;
  logic [11:0] screen_width_r;
  logic [11:0] screen_height_r;
  logic [23:0] sky_color_r;
  logic [23:0] floor_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r     <= 9'd64;
      tex_height_r    <= 9'd64;
      screen_width_r  <= 12'd640;
      screen_height_r <= 12'd480;
      sky_color_r     <= '0;
      floor_color_r   <= '0;
    end else if (cfg_we) begin
      case (rctw_pkg::cfg_reg_t'(cfg_index))
        rctw_pkg::CFG_TEX_WIDTH:     tex_width_r     <= cfg_data[8:0];
        rctw_pkg::CFG_TEX_HEIGHT:    tex_height_r    <= cfg_data[8:0];
        rctw_pkg::CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data[11:0];
        rctw_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data[11:0];
        rctw_pkg::CFG_SKY_COLOR:     sky_color_r     <= cfg_data;
        rctw_pkg::CFG_FLOOR_COLOR:   floor_color_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched column inputs
  logic [21:0] pos_sel_r;
  logic [17:0] ray_sel_r;
  logic [23:0] perp_r;
  logic        side_r;
  logic        rdx_neg_r;
  logic        rdy_neg_r;
  logic [15:0] lh_r;
  logic [10:0] ds_r;

  always_ff @(posedge clk) begin
    if (cmd.col_load) begin
      pos_sel_r <= in_item.hit_side ? in_item.pos_x : in_item.pos_y;
      ray_sel_r <= in_item.hit_side ? in_item.ray_dir_x : in_item.ray_dir_y;
      perp_r    <= in_item.perp_dist;
      side_r    <= in_item.hit_side;
      rdx_neg_r <= in_item.ray_dir_x[17];
      rdy_neg_r <= in_item.ray_dir_y[17];
      lh_r      <= in_item.line_height;
      ds_r      <= in_item.draw_start;
    end
  end

  // column setup pipeline
  logic signed [rctw_pkg::PROD_W-1:0] prod_r;
  logic [HW-1:0]                      hit_sum;
  logic [FRAC_BITS-1:0]               frac_r;
  logic signed [rctw_pkg::OFF_W-1:0]  off_r;
  logic [CPW-1:0]                     colprod_r;
  logic [8:0]                         col9;
  logic [8:0]                         col_mirr;
  logic [8:0]                         col_sel;
  logic                               mirror;

  assign hit_sum  = HW'({pos_sel_r, {FRAC_BITS{1'b0}}}) + HW'(prod_r);
  assign col9     = colprod_r[CPW-1:FRAC_BITS];
  assign col_mirr = tex_width_r - col9 - 9'd1;
  assign mirror   = side_r ? rdy_neg_r : !rdx_neg_r;
  assign col_sel  = mirror ? col_mirr : col9;

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod_r <= $signed({1'b0, perp_r}) * $signed(ray_sel_r);
    end
    if (cmd.sum_en) begin
      frac_r <= hit_sum[HW-1:FRAC_BITS];
      off_r  <= $signed({6'd0, ds_r}) - $signed({6'd0, screen_height_r[11:1]})
              + $signed({2'd0, lh_r[15:1]});
    end
    if (cmd.col_en) begin
      colprod_r <= frac_r * tex_width_r;
    end
  end

  // step division
  logic [DW-1:0] div_quo;
  logic          div_last;
  logic [15:0]   divisor;
  logic [QX-1:0] quo_ext;
  logic [31:0]   step_val;
  logic signed [rctw_pkg::OFF_W+rctw_pkg::STEP_W:0] pos_prod;

  assign divisor  = (lh_r == 16'd0) ? 16'd1 : lh_r;
  assign quo_ext  = QX'(div_quo);
  assign step_val = (|quo_ext[QX-1:rctw_pkg::STEP_W]) ? '1 : quo_ext[rctw_pkg::STEP_W-1:0];
  assign pos_prod = off_r * $signed({1'b0, step_val});

  rctw_div #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (rctw_pkg::LH_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mirr_en),
    .dividend ({tex_width_r, {FRAC_BITS{1'b0}}}),
    .divisor  (divisor),
    .quotient (div_quo),
    .last     (div_last)
  );

  // column state
  logic [10:0] cur_column_r;
  logic [11:0] row_count_r;
  logic [11:0] row_count_nxt;
  logic [10:0] slice_top_r;
  logic [10:0] slice_bottom_r;
  logic [7:0]  tex_column_r;
  logic [1:0]  tex_select_r;
  logic [39:0] tex_position_r;
  logic [39:0] tex_position_nxt;
  logic [31:0] tex_step_r;

  // row evaluation
  logic [12:0] eff_h;
  logic        row_active;
  logic        row_fire;
  logic        is_sky;
  logic        is_wall;
  logic [8:0]  hmask;
  logic [8:0]  trow;
  logic [17:0] texel_prod;
  logic [15:0] texel_sum;
  logic [23:0] addr_prod;
  rctw_pkg::out_item_t row_item;

  assign eff_h      = ({1'b0, screen_height_r} < 13'(rctw_pkg::MAX_SCREEN))
                    ? {1'b0, screen_height_r} : 13'(rctw_pkg::MAX_SCREEN);
  assign row_active = {1'b0, row_count_r} < eff_h;
  assign row_fire   = cmd.row_load && row_active;
  assign is_sky     = row_count_r < {1'b0, slice_top_r};
  assign is_wall    = !is_sky && (row_count_r <= {1'b0, slice_bottom_r});
  assign hmask      = tex_height_r - 9'd1;
  assign trow       = tex_position_r[FRAC_BITS+8:FRAC_BITS] & hmask;
  assign texel_prod = trow * tex_width_r;
  assign texel_sum  = texel_prod[15:0] + {8'd0, tex_column_r};
  assign addr_prod  = row_count_r * screen_width_r;

  always_comb begin
    row_item.pixel_addr  = addr_prod[21:0] + {11'd0, cur_column_r};
    row_item.texture_id  = tex_select_r;
    row_item.last_row    = (({1'b0, row_count_r} + 13'd1) == {1'b0, screen_height_r});
    if (is_sky) begin
      row_item.region      = rctw_pkg::REGION_SKY;
      row_item.texel_index = '0;
      row_item.flat_color  = sky_color_r;
    end else if (is_wall) begin
      row_item.region      = rctw_pkg::REGION_WALL;
      row_item.texel_index = texel_sum;
      row_item.flat_color  = '0;
    end else begin
      row_item.region      = rctw_pkg::REGION_FLOOR;
      row_item.texel_index = '0;
      row_item.flat_color  = floor_color_r;
    end
  end

  always_comb begin
    row_count_nxt = row_count_r;
    if (cmd.col_load) begin
      row_count_nxt = '0;
    end else if (row_fire) begin
      row_count_nxt = row_count_r + 12'd1;
    end
  end

  always_comb begin
    tex_position_nxt = tex_position_r;
    if (cmd.pos_en) begin
      tex_position_nxt = pos_prod[rctw_pkg::POS_W-1:0];
    end else if (row_fire && is_wall) begin
      tex_position_nxt = tex_position_r + {8'd0, tex_step_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_column_r   <= '0;
      row_count_r    <= '0;
      slice_top_r    <= '0;
      slice_bottom_r <= '0;
      tex_column_r   <= '0;
      tex_select_r   <= '0;
      tex_position_r <= '0;
      tex_step_r     <= '0;
    end else begin
      row_count_r    <= row_count_nxt;
      tex_position_r <= tex_position_nxt;
      if (cmd.col_load) begin
        cur_column_r   <= in_item.column;
        slice_top_r    <= in_item.draw_start;
        slice_bottom_r <= in_item.draw_end;
        if (in_item.hit_side) begin
          tex_select_r <= in_item.ray_dir_y[17] ? rctw_pkg::TEX_NORTH : rctw_pkg::TEX_SOUTH;
        end else begin
          tex_select_r <= in_item.ray_dir_x[17] ? rctw_pkg::TEX_WEST : rctw_pkg::TEX_EAST;
        end
      end
      if (cmd.mirr_en) begin
        tex_column_r <= col_sel[7:0] & rctw_pkg::TEX_COL_MASK;
      end
      if (cmd.pos_en) begin
        tex_step_r <= step_val;
      end
    end
  end

  // result queue: head in q0, overflow in q1
  rctw_pkg::out_item_t q0_r;
  rctw_pkg::out_item_t q1_r;
  logic [1:0]          cnt_r;
  logic                pop;

  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (row_fire && !pop) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (pop && !row_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0_r <= (row_fire && (cnt_r == 2'd1)) ? row_item : q1_r;
      if (row_fire) begin
        q1_r <= row_item;
      end
    end else if (row_fire) begin
      if (cnt_r == 2'd0) begin
        q0_r <= row_item;
      end else begin
        q1_r <= row_item;
      end
    end
  end

  assign out_item          = q0_r;
  assign out_valid         = (cnt_r != 2'd0);
  assign status.queue_full = (cnt_r == 2'd2);
  assign status.div_last   = div_last;

endmodule
`default_nettype wire

// ===== hw/rtl/raycast_column_texture_walker_core.sv =====
// Row item: result is registered into a two-entry result queue; one row per cycle sustained
//   while the queue is not full, so rows keep flowing while one result waits.
// Column start: input is held off through the PROD, SUM, COL, MIRR, DIV and POS states,
//   DIV waiting on the bit-serial step divider, one quotient bit per cycle.
// Reset (rst_n low, synchronous) restores the register defaults and clears column state.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raycast_column_texture_walker_core
// Wall texture column walker: column setup, then one pixel per in-screen row item.
// ----------------------------------------------------------------------------
module raycast_column_texture_walker_core #(
  parameter int FRAC_BITS = rctw_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rctw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rctw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // column, pos_x, pos_y, ray_dir_x, ray_dir_y, perp_dist, hit_side,
  // line_height, draw_start, draw_end, zero fill
  input  logic [rctw_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pixel_addr, texel_index, flat_color, zero fill
  output logic [rctw_pkg::OUT_TDATA_W-1:0] out_tdata,
  // region, texture_id
  output logic [rctw_pkg::OUT_TUSER_W-1:0] out_tuser,
  // last_row
  output logic                             out_tlast
);

  rctw_pkg::in_item_t   in_item;
  rctw_pkg::out_item_t  out_item;
  rctw_pkg::ctrl_cmd_t  cmd;
  rctw_pkg::dp_status_t status;

  always_comb begin
    in_item.op          = in_tuser;
    in_item.column      = in_tdata[10:0];
    in_item.pos_x       = in_tdata[32:11];
    in_item.pos_y       = in_tdata[54:33];
    in_item.ray_dir_x   = in_tdata[72:55];
    in_item.ray_dir_y   = in_tdata[90:73];
    in_item.perp_dist   = in_tdata[114:91];
    in_item.hit_side    = in_tdata[115];
    in_item.line_height = in_tdata[131:116];
    in_item.draw_start  = in_tdata[142:132];
    in_item.draw_end    = in_tdata[153:143];
  end

  assign cfg_ready = 1'b1;

  rctw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_item.op),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rctw_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = {2'd0, out_item.flat_color, out_item.texel_index, out_item.pixel_addr};
  assign out_tuser = {out_item.texture_id, out_item.region};
  assign out_tlast = out_item.last_row;

endmodule
`default_nettype wire

// ===== hw/rtl/rctw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rctw_checker
// Port-level checks for the column texture walker, bound to the top level.
// ----------------------------------------------------------------------------
`include "raycast_column_texture_walker_core_defines.svh"

module rctw_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rctw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [rctw_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                             out_tlast
);

  logic [rctw_pkg::OUT_TDATA_W+rctw_pkg::OUT_TUSER_W:0] out_beat;

  assign out_beat = {out_tlast, out_tuser, out_tdata};

  // a stalled result stays offered
  `RCTW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  `RCTW_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_beat))

  // column setup blocks the input for at least the next cycle
  `RCTW_ASSERT_NEXT(a_col_busy, clk, rst_n, in_tvalid && in_tready && !in_tuser, !in_tready)

  // a column start never produces a result
  `RCTW_ASSERT_NEXT(a_col_silent, clk, rst_n, in_tvalid && in_tready && !in_tuser && !out_tvalid, !out_tvalid)

  `RCTW_ASSERT_NOW(a_region_code, clk, rst_n, out_tvalid, out_tuser[1:0] != 2'd3)

endmodule

bind raycast_column_texture_walker_core rctw_checker u_rctw_checker (.*);
`default_nettype wire

// ===== dv/rctw_pixel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctw_pixel_checker
// Watches the configuration, column/row and pixel channels of the column
// texture walker, predicts each pixel from the accepted items and compares
// every accepted pixel, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module rctw_pixel_checker
  import rctw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   out_tlast,
  output int                     fail_count,
  output int                     pending,
  output int                     pixels_checked
);

  localparam int FRAC = FRAC_BITS_DEF;

  // register image
  logic [8:0]  tex_w, tex_h;
  logic [11:0] scr_w, scr_h;
  logic [23:0] sky_rgb, floor_rgb;

  // column state
  logic [10:0] col_idx;
  logic [11:0] row_cnt;
  logic [10:0] slice_top, slice_bot;
  logic [7:0]  tex_col;
  logic [1:0]  tex_sel;
  logic [39:0] tex_pos;
  logic [31:0] tex_stp;

  out_item_t expected_pixels[$];
  out_item_t got, want;
  in_item_t  item;
  logic [5:0] pad;
  logic       emitted;
  int         errs = 0;
  int         checked = 0;

  task automatic latch_column(input in_item_t it);
    logic signed [17:0] rx, ry;
    longint      hit, off;
    logic [15:0] frac;
    logic [63:0] col, step, prod;
    logic        mirror;
    rx = it.ray_dir_x;
    ry = it.ray_dir_y;
    // exact wall hit with 2F fraction bits; the texture coordinate is bits F..2F-1
    if (it.hit_side == 1'b0)
      hit = (longint'(it.pos_y) << FRAC) + longint'(it.perp_dist) * longint'(ry);
    else
      hit = (longint'(it.pos_x) << FRAC) + longint'(it.perp_dist) * longint'(rx);
    frac = 16'(hit >> FRAC);
    col = (64'(frac) * 64'(tex_w)) >> FRAC;
    mirror = (it.hit_side == 1'b0) ? !rx[17] : ry[17];
    if (mirror)
      col = 64'(tex_w) - col - 64'd1;
    tex_col = col[7:0];
    if (it.hit_side == 1'b1)
      tex_sel = ry[17] ? TEX_NORTH : TEX_SOUTH;
    else
      tex_sel = rx[17] ? TEX_WEST : TEX_EAST;
    step = (64'(tex_w) << FRAC) / ((it.line_height == '0) ? 64'd1 : 64'(it.line_height));
    if (step > 64'hFFFF_FFFF)
      step = 64'hFFFF_FFFF;
    tex_stp = step[31:0];
    off = longint'(it.draw_start) - longint'(scr_h >> 1) + longint'(it.line_height >> 1);
    prod = 64'(off) * 64'(tex_stp);
    tex_pos = prod[39:0];
    col_idx = it.column;
    slice_top = it.draw_start;
    slice_bot = it.draw_end;
    row_cnt = '0;
  endtask

  task automatic shade_next_row(output logic emit, output out_item_t px);
    int          eff;
    logic [11:0] r;
    logic [8:0]  hmask;
    logic [23:0] trow;
    logic [63:0] texel, addr;
    eff = (int'(scr_h) < MAX_SCREEN) ? int'(scr_h) : MAX_SCREEN;
    emit = 1'b0;
    px = '0;
    if (int'(row_cnt) < eff) begin
      r = row_cnt;
      if (r < slice_top) begin
        px.region = REGION_SKY;
        px.flat_color = sky_rgb;
      end else if (r <= slice_bot) begin
        hmask = tex_h - 9'd1;
        trow = tex_pos[39:16] & {15'b0, hmask};
        texel = 64'(trow) * 64'(tex_w) + 64'(tex_col);
        px.region = REGION_WALL;
        px.texel_index = texel[15:0];
        tex_pos = tex_pos + 40'(tex_stp);
      end else begin
        px.region = REGION_FLOOR;
        px.flat_color = floor_rgb;
      end
      addr = 64'(r) * 64'(scr_w) + 64'(col_idx);
      px.pixel_addr = addr[21:0];
      px.texture_id = tex_sel;
      px.last_row = (int'(r) + 1 == int'(scr_h));
      row_cnt = r + 12'd1;
      emit = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want_v, got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tex_w = 9'd64;
      tex_h = 9'd64;
      scr_w = 12'd640;
      scr_h = 12'd480;
      sky_rgb = '0;
      floor_rgb = '0;
      col_idx = '0;
      row_cnt = '0;
      slice_top = '0;
      slice_bot = '0;
      tex_col = '0;
      tex_sel = '0;
      tex_pos = '0;
      tex_stp = '0;
      expected_pixels.delete();
    end else begin
      // compare before pushing: a pixel leaving now belongs to an earlier row item
      if (out_tvalid && out_tready) begin
        got.pixel_addr  = out_tdata[21:0];
        got.texel_index = out_tdata[37:22];
        got.flat_color  = out_tdata[61:38];
        got.region      = out_tuser[1:0];
        got.texture_id  = out_tuser[3:2];
        got.last_row    = out_tlast;
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel transfer: pixel_addr %0h", got.pixel_addr);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_addr", 24'(want.pixel_addr), 24'(got.pixel_addr));
          check_field("region", 24'(want.region), 24'(got.region));
          check_field("texture_id", 24'(want.texture_id), 24'(got.texture_id));
          check_field("texel_index", 24'(want.texel_index), 24'(got.texel_index));
          check_field("flat_color", want.flat_color, got.flat_color);
          check_field("last_row", 24'(want.last_row), 24'(got.last_row));
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEX_WIDTH:     tex_w = cfg_data[8:0];
          CFG_TEX_HEIGHT:    tex_h = cfg_data[8:0];
          CFG_SCREEN_WIDTH:  scr_w = cfg_data[11:0];
          CFG_SCREEN_HEIGHT: scr_h = cfg_data[11:0];
          CFG_SKY_COLOR:     sky_rgb = cfg_data;
          CFG_FLOOR_COLOR:   floor_rgb = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        item = '0;
        {pad, item.draw_end, item.draw_start, item.line_height, item.hit_side,
         item.perp_dist, item.ray_dir_y, item.ray_dir_x, item.pos_y, item.pos_x,
         item.column} = in_tdata;
        item.op = in_tuser;
        if (item.op == OP_COLUMN) begin
          latch_column(item);
        end else begin
          shade_next_row(emitted, want);
          if (emitted)
            expected_pixels.push_back(want);
        end
      end
    end
    pending <= expected_pixels.size();
    fail_count <= errs;
    pixels_checked <= checked;
  end

endmodule

// ===== dv/tb_raycast_column_texture_walker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_raycast_column_texture_walker_core
// Drives column starts and row requests with random gaps and back-pressure,
// walks the registers through several settings and lets the pixel checker
// judge every transfer on the result channel.
// ----------------------------------------------------------------------------
module tb_raycast_column_texture_walker_core;
  import rctw_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 560;
  localparam int TAIL_ROWS     = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int fail_count, pending, pixels_checked;
  int hold_ask = 0;
  bit idle_on = 1'b1;
  int cur_sh = 480;
  int n_columns = 0;
  int n_rows = 0;
  int n_settings = 1;

  always #4 clk = ~clk;

  raycast_column_texture_walker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  rctw_pixel_checker pixel_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending        (pending),
    .pixels_checked (pixels_checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [8:0] pick_tex();
    if ($urandom_range(0, 4) != 0)
      return 9'(1 << $urandom_range(0, 8));
    return 9'($urandom);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_column(input in_item_t it);
    return {6'b0, it.draw_end, it.draw_start, it.line_height, it.hit_side, it.perp_dist,
            it.ray_dir_y, it.ray_dir_x, it.pos_y, it.pos_x, it.column};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] col_item(
    input logic [10:0] column, input logic [21:0] px, py, input logic [17:0] rx, ry,
    input logic [23:0] perp, input logic side, input logic [15:0] lh,
    input logic [10:0] ds, de);
    in_item_t it;
    it = '{op: OP_COLUMN, column: column, pos_x: px, pos_y: py, ray_dir_x: rx,
           ray_dir_y: ry, perp_dist: perp, hit_side: side, line_height: lh,
           draw_start: ds, draw_end: de};
    return pack_column(it);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_column(input int sh);
    int lim, a, b, sel;
    in_item_t it;
    lim = (sh > 2047) ? 2047 : sh;
    it.op = OP_COLUMN;
    it.column = 11'($urandom);
    it.pos_x = 22'($urandom);
    it.pos_y = 22'($urandom);
    it.ray_dir_x = ($urandom_range(0, 9) == 0) ? 18'd0 : 18'($urandom);
    it.ray_dir_y = ($urandom_range(0, 9) == 0) ? 18'd0 : 18'($urandom);
    it.perp_dist = 24'($urandom);
    it.hit_side = 1'($urandom);
    sel = $urandom_range(0, 9);
    if (sel == 0) it.line_height = 16'd0;
    else if (sel == 1) it.line_height = 16'($urandom);
    else it.line_height = 16'($urandom_range(1, 2 * lim + 8));
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      a = $urandom_range(0, lim);
      b = $urandom_range(a, lim);
    end else if (sel < 9) begin
      // inverted slice
      a = $urandom_range(1, lim + 1);
      b = $urandom_range(0, a - 1);
    end else begin
      a = $urandom_range(0, 2047);
      b = $urandom_range(0, 2047);
    end
    it.draw_start = 11'(a);
    it.draw_end = 11'(b);
    return pack_column(it);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] noise_row();
    logic [IN_TDATA_W-1:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom};
    v[IN_TDATA_W-1:154] = '0;
    return v;
  endfunction

  // valid stays high across back-to-back transfers; lowered only for a gap
  task automatic send_item(input logic op, input logic [IN_TDATA_W-1:0] beat);
    int g;
    g = idle_on ? pick_gap() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_COLUMN) n_columns++;
    else n_rows++;
  endtask

  task automatic send_rows(input int count);
    for (int i = 0; i < count; i++)
      send_item(OP_ROW, noise_row());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [8:0] tw, th, input logic [11:0] sw, sh,
                              input logic [23:0] sky, flr, input bit poke_unmapped);
    write_reg(CFG_TEX_WIDTH, 24'(tw));
    write_reg(CFG_TEX_HEIGHT, 24'(th));
    write_reg(CFG_SCREEN_WIDTH, 24'(sw));
    write_reg(CFG_SCREEN_HEIGHT, 24'(sh));
    write_reg(CFG_SKY_COLOR, sky);
    write_reg(CFG_FLOOR_COLOR, flr);
    if (poke_unmapped) begin
      write_reg(CFG_UNMAPPED_LO, 24'hFFFFFF);
      write_reg(CFG_UNMAPPED_HI, 24'($urandom));
    end
    cfg_valid <= 1'b0;
    cur_sh = sh;
    n_settings++;
  endtask

  // drop valid and hold off until every predicted pixel has been seen
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // a column start may still be in its divide with nothing pending
  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result-side flow control
  initial begin
    int g, calm, hold_seen;
    calm = 0;
    hold_seen = 0;
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (calm > 0) begin
        calm--;
      end else begin
        if ($urandom_range(0, 15) == 0)
          calm = $urandom_range(50, 300);
        g = pick_gap();
        if (g > 0) begin
          out_tready <= 1'b0;
          repeat (g) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int rand_items, phase, ncols, nrows, waited;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_tvalid <= 1'b0;
    in_tuser <= 1'b0;
    in_tdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rows before any column, then corner columns
    send_rows(2);
    send_item(OP_COLUMN, col_item(11'd0, 22'd0, 22'd0, 18'd0, 18'd0, 24'd0, 1'b0,
                                  16'd1, 11'd0, 11'd479));
    send_rows(3);
    quiesce();
    program_regs(9'd256, 9'd0, 12'd4095, 12'd3, 24'hFFFFFF, 24'h000000, 1'b1);
    send_item(OP_COLUMN, col_item(11'd2047, 22'h3FFFFF, 22'h3FFFFF, 18'h20000, 18'h20000,
                                  24'hFFFFFF, 1'b1, 16'hFFFF, 11'd0, 11'd2047));
    send_rows(4);
    send_item(OP_COLUMN, col_item(11'd1234, 22'($urandom), 22'($urandom), 18'h3FFFF,
                                  18'h1FFFF, 24'($urandom), 1'b0, 16'd0, 11'd2, 11'd1));
    send_rows(4);
    send_item(OP_COLUMN, col_item(11'd5, 22'($urandom), 22'($urandom), 18'h1FFFF, 18'd0,
                                  24'($urandom), 1'b1, 16'd2, 11'd1, 11'd1));
    send_rows(4);
    quiesce();

    rand_items = 0;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case (phase)
        0: program_regs(9'd1, 9'd1, 12'd1, 12'd1, 24'h000000, 24'h000000, 1'b0);
        1: program_regs(9'd256, 9'd256, 12'd4095, 12'd2, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        2: program_regs(9'd511, 9'd511, 12'($urandom), 12'd0, 24'($urandom), 24'($urandom),
                        1'b1);
        3: program_regs(pick_tex(), pick_tex(), 12'($urandom_range(1, 4095)), 12'd16,
                        24'($urandom), 24'($urandom), 1'b0);
        default: program_regs(pick_tex(), pick_tex(), 12'($urandom_range(1, 4095)),
                              12'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 20)
                                                             : $urandom_range(21, 64)),
                              24'($urandom), 24'($urandom), 1'b0);
      endcase
      ncols = (phase == 2) ? 2 : $urandom_range(2, 6);
      // long receiver stall while rows keep coming
      if (phase == 3) hold_ask++;
      for (int c = 0; c < ncols && rand_items < RANDOM_ITEMS; c++) begin
        idle_on = ($urandom_range(0, 3) != 0);
        send_item(OP_COLUMN, random_column(cur_sh));
        if (phase == 2) nrows = 3;
        else if ($urandom_range(0, 9) < 7) nrows = cur_sh + $urandom_range(0, 2);
        else nrows = $urandom_range(0, cur_sh + 1);
        send_rows(nrows);
        rand_items += 1 + nrows;
        if (phase == 4 && c == 0) drain_results();
      end
      quiesce();
      phase++;
    end

    // largest screen: wide row stride and tall screen on a short column
    program_regs(pick_tex(), pick_tex(), 12'd4095, 12'd4095, 24'($urandom), 24'($urandom),
                 1'b0);
    idle_on = 1'b0;
    send_item(OP_COLUMN, random_column(cur_sh));
    send_rows(TAIL_ROWS);
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run drove %0d column starts and %0d row requests over %0d register settings;",
             n_columns, n_rows, n_settings);
    $display("%0d pixels compared, %0d still outstanding.", pixels_checked, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
